// ===== rtl/core/fifo_id_pool_allocator_defines.svh =====
// assertion macros used by the id pool control rtl
`ifndef FIFO_ID_POOL_ALLOCATOR_DEFINES_SVH
`define FIFO_ID_POOL_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// property that holds in every cycle
`define IDP_ASSERT_COMB(label, dis, expr, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (expr)) else $error(msg);
// property that holds in the cycle after its trigger
`define IDP_ASSERT_NEXT(label, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);
`else
`define IDP_ASSERT_COMB(label, dis, expr, msg)
`define IDP_ASSERT_NEXT(label, dis, ante, cons, msg)
`endif
`endif

// ===== rtl/core/idpool_pkg.sv =====
// types, constants and helpers for the id pool allocator
`default_nettype none
package idpool_pkg;

  localparam int NUM_IDS = 128;
  localparam int ID_W    = $clog2(NUM_IDS);
  localparam int CNT_W   = ID_W + 1;
  localparam int CFG_W   = 8;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CHECK   = 2'd2
  } mode_t;

  // request from the pool control to the free ring
  typedef struct packed {
    logic            reinit;
    logic            we;
    logic [ID_W-1:0] waddr;
    logic [ID_W-1:0] wdata;
    logic [ID_W-1:0] raddr;
  } ring_req_t;

  // effective pool size: zero means one, large values saturate
  function automatic logic [CNT_W-1:0] pool_size(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] s;
    if (v == '0) begin
      s = CNT_W'(1);
    end else if (32'(v) > NUM_IDS) begin
      s = CNT_W'(NUM_IDS);
    end else begin
      s = CNT_W'(v);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/idpool_ring.sv =====
// free id ring memory with a registered read of the head entry
`default_nettype none
module idpool_ring import idpool_pkg::*; (
  input  wire logic            clk,
  input  ring_req_t            req,
  output logic      [ID_W-1:0] head_id
);

  logic [ID_W-1:0]    ring_mem [NUM_IDS];
  logic [NUM_IDS-1:0] written;
  logic [ID_W-1:0]    rd_data;
  logic               rd_written;
  logic [ID_W-1:0]    rd_addr;
  logic               byp;
  logic [ID_W-1:0]    byp_data;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      ring_mem[req.waddr] <= req.wdata;
    end
    rd_data  <= ring_mem[req.raddr];
    byp_data <= req.wdata;
  end

  // written flags stand in for the identity fill after reinit
  always_ff @(posedge clk) begin
    if (req.reinit) begin
      written    <= '0;
      rd_written <= 1'b0;
      rd_addr    <= '0;
      byp        <= 1'b0;
    end else begin
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
      rd_written <= written[req.raddr];
      rd_addr    <= req.raddr;
      byp        <= req.we && (req.waddr == req.raddr);
    end
  end

  // head entry: same-cycle write wins, unwritten entry holds its index
  assign head_id = byp ? byp_data : (rd_written ? rd_data : rd_addr);

endmodule
`default_nettype wire

// ===== rtl/core/idpool_ctrl.sv =====
// pool pointers, per-id taken flags, request decode and result register
`default_nettype none
`include "fifo_id_pool_allocator_defines.svh"
module idpool_ctrl import idpool_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             op_valid,
  input  wire logic [1:0]       mode_q,
  input  wire logic [ID_W-1:0]  id_q,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic [ID_W-1:0]  head_id,
  output ring_req_t             ring_req,
  output logic                  done,
  output logic      [ID_W-1:0]  granted_id,
  output logic                  status,
  output logic                  available
);

  logic [CFG_W-1:0]   ids_in_use;
  logic [ID_W-1:0]    head;
  logic [ID_W-1:0]    head_next;
  logic [ID_W-1:0]    tail;
  logic [ID_W-1:0]    tail_next;
  logic [CNT_W-1:0]   free_count;
  logic [CNT_W-1:0]   free_count_next;
  logic [NUM_IDS-1:0] taken;
  logic [NUM_IDS-1:0] taken_next;
  logic [CNT_W-1:0]   pool_sz;
  logic [CNT_W-1:0]   init_sz;
  logic [CNT_W-1:0]   head_inc;
  logic [CNT_W-1:0]   tail_inc;
  logic               in_range;
  logic               id_taken;
  logic               alloc_ok;
  logic               rel_ok;
  logic               rel_rej;
  logic [ID_W-1:0]    res_id;
  logic               res_status;
  logic               res_avail;

  assign pool_sz  = pool_size(ids_in_use);
  assign init_sz  = rst ? CNT_W'(NUM_IDS) : pool_size(cfg_data);
  assign in_range = {1'b0, id_q} < pool_sz;
  assign id_taken = taken[id_q];
  assign head_inc = {1'b0, head} + CNT_W'(1);
  assign tail_inc = {1'b0, tail} + CNT_W'(1);

  // request decode
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    free_count_next = free_count;
    taken_next      = taken;
    alloc_ok        = 1'b0;
    rel_ok          = 1'b0;
    rel_rej         = 1'b0;
    res_id          = '0;
    res_status      = 1'b0;
    res_avail       = 1'b0;
    if (op_valid) begin
      unique case (mode_t'(mode_q))
        MODE_ALLOC: begin
          if (free_count == '0) begin
            res_status = 1'b1;
          end else begin
            alloc_ok            = 1'b1;
            res_id              = head_id;
            taken_next[head_id] = 1'b1;
            head_next           = (head_inc >= pool_sz) ? '0 : head_inc[ID_W-1:0];
            free_count_next     = free_count - CNT_W'(1);
          end
        end
        MODE_RELEASE: begin
          if (!in_range || !id_taken) begin
            rel_rej    = 1'b1;
            res_status = 1'b1;
          end else begin
            rel_ok           = 1'b1;
            taken_next[id_q] = 1'b0;
            tail_next        = (tail_inc >= pool_sz) ? '0 : tail_inc[ID_W-1:0];
            free_count_next  = free_count + CNT_W'(1);
          end
        end
        MODE_CHECK: begin
          if (!in_range) begin
            res_status = 1'b1;
          end else begin
            res_avail = !id_taken;
          end
        end
        default: begin
          res_status = 1'b1;
        end
      endcase
    end
  end

  // ring access: released id goes to the new tail, next head is prefetched
  always_comb begin
    ring_req.reinit = rst || cfg_we;
    ring_req.we     = rel_ok;
    ring_req.waddr  = tail_next;
    ring_req.wdata  = id_q;
    ring_req.raddr  = head_next;
  end

  // pool state, reinit on reset or size write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      ids_in_use <= rst ? CFG_W'(NUM_IDS) : cfg_data;
      head       <= '0;
      tail       <= ID_W'(init_sz - CNT_W'(1));
      free_count <= init_sz;
      taken      <= '0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      free_count <= free_count_next;
      taken      <= taken_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= op_valid;
    end
    granted_id <= res_id;
    status     <= res_status;
    available  <= res_avail;
  end

  `IDP_ASSERT_COMB(a_count_bound, rst, free_count <= pool_sz, "free count above pool size")
  `IDP_ASSERT_NEXT(a_result_follows, rst, op_valid, done, "transaction produced no result")
  `IDP_ASSERT_NEXT(a_alloc_count, rst || cfg_we, alloc_ok, free_count == $past(free_count) - CNT_W'(1), "allocate did not consume a free id")
  `IDP_ASSERT_NEXT(a_reject_stable, rst || cfg_we, rel_rej, $stable(free_count) && $stable(tail), "rejected release changed the pool")
  `IDP_ASSERT_NEXT(a_alloc_marks, rst || cfg_we, alloc_ok, taken[$past(head_id)], "granted id not marked taken")

endmodule
`default_nettype wire

// ===== rtl/core/fifo_id_pool_allocator.sv =====
// id pool allocator top: free id ring, taken flags and request register
// a transaction is held in the request register, then its result is strobed from the result register
// throughput: one transaction per cycle, busy stays low, set by the single ring read port
// the result strobe lasts one cycle and the receiver cannot stall it
// reset (synchronous) and any size write refill the pool through the ring written flags, no clearing pass
`default_nettype none
module fifo_id_pool_allocator import idpool_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       mode,
  input  wire logic [ID_W-1:0]  id_in,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  done,
  output logic      [ID_W-1:0]  granted_id,
  output logic                  status,
  output logic                  available
);

  logic            op_valid;
  logic [1:0]      mode_q;
  logic [ID_W-1:0] id_q;
  ring_req_t       ring_req;
  logic [ID_W-1:0] head_id;

  assign busy = 1'b0;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= start && !busy;
    end
    mode_q <= mode;
    id_q   <= id_in;
  end

  idpool_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .mode_q     (mode_q),
    .id_q       (id_q),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .head_id    (head_id),
    .ring_req   (ring_req),
    .done       (done),
    .granted_id (granted_id),
    .status     (status),
    .available  (available)
  );

  idpool_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .head_id (head_id)
  );

endmodule
`default_nettype wire
